### rtl/size_class_block_allocator_defines.svh
// assertion macros for the size class block allocator
// included by modules that carry concurrent checks; needs nothing else
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SCBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SCBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/scba_pkg.sv
// shared constants, codes and types of the size class block allocator
// no dependencies
`timescale 1ns / 1ps

package scba_pkg;

  localparam int PAGE_SHIFT   = 12;
  localparam int MIN_SHIFT    = 3;
  localparam int BPP_SHIFT    = PAGE_SHIFT - MIN_SHIFT;
  localparam int MAX_PAGES    = 32;
  localparam int PAGE_IDX_W   = 5;
  localparam int PAGE_CNT_W   = 6;
  localparam int BLK_ID_W     = PAGE_IDX_W + BPP_SHIFT;
  localparam int TOTAL_BLOCKS = MAX_PAGES << BPP_SHIFT;
  localparam int NUM_CLASSES  = 9;
  localparam int CLS_W        = 4;
  localparam int LEN_W        = BLK_ID_W + 1;
  localparam int CNT_W        = BPP_SHIFT + 1;
  localparam int BYTES_W      = 12;
  localparam int MAX_CLASS_BYTES = (1 << MIN_SHIFT) << (NUM_CLASSES - 1);

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NO_BLOCK = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_TOO_BIG  = 3'd4,
    ST_RANGE    = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

  typedef enum logic {
    CFG_REGION_START = 1'b0,
    CFG_REGION_PAGES = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_SPLIT,
    S_WSTART,
    S_WALK,
    S_OUT
  } state_t;

endpackage

### rtl/scba_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module scba_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/size_class_block_allocator.sv
// size class block allocator top level: control, page tables, class lists
// depends on scba_pkg, scba_ram and size_class_block_allocator_defines.svh
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid/s_tready         tuser req_type, tdata size/addr/grant
// m_*      out  m_tvalid/m_tready         tuser status, tdata result fields
// cfg_*    in   cfg_we                    cfg_index, cfg_data
//
// query, error and list-hit requests go from decode (and a pop on a list hit) to the output handoff
// a page split appends each new block to the class list, (512>>class)-1 new blocks
// releasing a page adds a walk start state and a walk over every link of the class list
// the link memory has one write and one read port; the walk is the bound
// reset and config writes rebuild all tables; links are not cleared
// a result waits in the output register while the next item is taken
`timescale 1ns / 1ps
`include "size_class_block_allocator_defines.svh"

module size_class_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // request_size[15:0], block_address[47:16], page_grant[48]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // result_address[31:0], block_bytes[43:32],
                                 // page_claimed[44], page_released[45], page_address[77:46]
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PI = scba_pkg::PAGE_IDX_W;
  localparam int BI = scba_pkg::BLK_ID_W;
  localparam int NC = scba_pkg::NUM_CLASSES;
  localparam int NP = scba_pkg::MAX_PAGES;
  localparam int LW = scba_pkg::LEN_W;
  localparam int CW = scba_pkg::CNT_W;
  localparam int KW = scba_pkg::BPP_SHIFT;

  scba_pkg::state_t state_q, state_next;

  logic [31:0]                 start_q;
  logic [scba_pkg::PAGE_CNT_W-1:0] pages_q, total_q;
  logic [PI-1:0]               order_q [NP];
  logic [scba_pkg::CLS_W-1:0]  code_q [NP];
  logic [CW-1:0]               fblk_q [NP];
  logic [BI-1:0]               head_q [NC];
  logic [BI-1:0]               tail_q [NC];
  logic [LW-1:0]               len_q [NC];

  logic [1:0]  typ_q;
  logic [15:0] size_q;
  logic [31:0] addr_q;
  logic        grant_q;

  scba_pkg::status_t r_status;
  logic [31:0] r_addr, r_paddr;
  logic [scba_pkg::BYTES_W-1:0] r_bytes;
  logic        r_claim, r_rel;

  logic [scba_pkg::CLS_W-1:0] cls_q;
  logic [PI-1:0] pg_q;
  logic [KW-1:0] k_q;
  logic [BI-1:0] cur_q, whead_q, wtail_q;
  logic [LW-1:0] wlen_q, widx_q, wcnt_q;

  // link memory and forwarding
  logic          ram_we;
  logic [BI-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata, link_q, fwd_data_q;
  logic          fwd_hit_q;

  scba_ram #(.WIDTH(BI), .DEPTH(scba_pkg::TOTAL_BLOCKS)) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    fwd_hit_q  <= ram_we && (ram_waddr == ram_raddr);
    fwd_data_q <= ram_wdata;
  end

  assign link_q = fwd_hit_q ? fwd_data_q : ram_rdata;

  // allocate decode
  logic [scba_pkg::CLS_W-1:0] a_cls, d_cls;
  logic        too_big, a_hit, d_found;
  logic [PI-1:0] top_pg;
  logic [31:0] top_paddr;

  always_comb begin
    a_cls = '0;
    for (int k = 0; k < NC; k++) begin
      if (size_q > 16'((1 << scba_pkg::MIN_SHIFT) << k)) begin
        a_cls = a_cls + 1'b1;
      end
    end
    too_big = size_q > 16'(scba_pkg::MAX_CLASS_BYTES);
    a_hit   = len_q[a_cls] != '0;
    d_found = 1'b0;
    d_cls   = '0;
    for (int d = NC - 1; d >= 0; d--) begin
      if (d > int'(a_cls) && len_q[d] != '0) begin
        d_found = 1'b1;
        d_cls   = scba_pkg::CLS_W'(d);
      end
    end
    top_pg    = order_q[PI'(total_q - 1'b1)];
    top_paddr = start_q + {top_pg, {scba_pkg::PAGE_SHIFT{1'b0}}};
  end

  // free and query decode
  logic [32:0] reg_hi;
  logic        in_reg, f_full;
  logic [31:0] f_off;
  logic [PI-1:0] f_pg;
  logic [scba_pkg::CLS_W-1:0] f_code, f_cls;
  logic [scba_pkg::BYTES_W-1:0] f_sz, f_blk_off;
  logic [BI-1:0] f_id;
  logic [CW-1:0] f_cnt, f_n;

  always_comb begin
    reg_hi    = {1'b0, start_q} + {15'd0, pages_q, {scba_pkg::PAGE_SHIFT{1'b0}}};
    in_reg    = ({1'b0, addr_q} >= {1'b0, start_q}) && ({1'b0, addr_q} < reg_hi);
    f_off     = addr_q - start_q;
    f_pg      = f_off[scba_pkg::PAGE_SHIFT +: PI];
    f_code    = code_q[f_pg];
    f_cls     = f_code - 1'b1;
    f_sz      = scba_pkg::BYTES_W'(1 << scba_pkg::MIN_SHIFT) << f_cls;
    f_blk_off = f_off[scba_pkg::PAGE_SHIFT-1:0] & ~(f_sz - 1'b1);
    f_id      = {f_pg, f_blk_off[scba_pkg::PAGE_SHIFT-1:scba_pkg::MIN_SHIFT]};
    f_cnt     = fblk_q[f_pg] + 1'b1;
    f_n       = CW'(1 << KW) >> f_cls;
    f_full    = f_cnt == f_n;
  end

  // split and walk step values
  logic [CW-1:0] s_n;
  logic [KW-1:0] s_last;
  logic [BI-1:0] s_id;
  logic          w_keep, w_done;
  logic [BI-1:0] w_head, w_tail;
  logic [LW-1:0] w_cnt;

  always_comb begin
    s_n    = CW'(1 << KW) >> cls_q;
    s_last = KW'(s_n - 1'b1);
    s_id   = {pg_q, KW'(k_q << cls_q)};
    w_keep = cur_q[BI-1 -: PI] != pg_q;
    w_done = widx_q == wlen_q - 1'b1;
    w_head = (w_keep && wcnt_q == '0) ? cur_q : whead_q;
    w_tail = w_keep ? cur_q : wtail_q;
    w_cnt  = w_keep ? wcnt_q + 1'b1 : wcnt_q;
  end

  // next state
  always_comb begin
    state_next = state_q;
    case (state_q)
      scba_pkg::S_IDLE: begin
        if (s_tvalid && s_tready) state_next = scba_pkg::S_DECODE;
      end
      scba_pkg::S_DECODE: begin
        state_next = scba_pkg::S_OUT;
        case (typ_q)
          scba_pkg::REQ_ALLOC: begin
            if (size_q != '0 && !too_big) begin
              if (a_hit) state_next = scba_pkg::S_POP;
              else if (total_q != '0) begin
                if (grant_q) state_next = scba_pkg::S_SPLIT;
              end else if (d_found) state_next = scba_pkg::S_POP;
            end
          end
          scba_pkg::REQ_FREE: begin
            if (in_reg && f_code != '0 && f_full) state_next = scba_pkg::S_WSTART;
          end
          default: state_next = scba_pkg::S_OUT;
        endcase
      end
      scba_pkg::S_POP:    state_next = scba_pkg::S_OUT;
      scba_pkg::S_SPLIT:  if (k_q == s_last) state_next = scba_pkg::S_OUT;
      scba_pkg::S_WSTART: state_next = scba_pkg::S_WALK;
      scba_pkg::S_WALK:   if (w_done) state_next = scba_pkg::S_OUT;
      scba_pkg::S_OUT:    if (!m_tvalid || m_tready) state_next = scba_pkg::S_IDLE;
      default:            state_next = scba_pkg::S_IDLE;
    endcase
  end

  // handshake and link memory controls
  always_comb begin
    s_tready  = state_q == scba_pkg::S_IDLE && !rst && !cfg_we;
    ram_we    = 1'b0;
    ram_waddr = s_id;
    ram_wdata = s_id;
    ram_raddr = head_q[cls_q];
    case (state_q)
      scba_pkg::S_DECODE: begin
        ram_we    = typ_q == scba_pkg::REQ_FREE && in_reg && f_code != '0;
        ram_waddr = f_id;
        ram_wdata = head_q[f_cls];
        ram_raddr = head_q[a_hit ? a_cls : d_cls];
      end
      scba_pkg::S_SPLIT: begin
        ram_we    = len_q[cls_q] != '0;
        ram_waddr = tail_q[cls_q];
        ram_wdata = s_id;
      end
      scba_pkg::S_WALK: begin
        ram_we    = w_keep && wcnt_q != '0;
        ram_waddr = wtail_q;
        ram_wdata = cur_q;
        ram_raddr = link_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // datapath and tables
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      if (rst) begin
        start_q <= '0;
        pages_q <= '0;
        total_q <= '0;
        for (int i = 0; i < NP; i++) order_q[i] <= '0;
      end else if (cfg_index == scba_pkg::CFG_REGION_START) begin
        start_q <= {cfg_data[31:scba_pkg::PAGE_SHIFT], {scba_pkg::PAGE_SHIFT{1'b0}}};
        total_q <= pages_q;
        for (int i = 0; i < NP; i++) begin
          order_q[i] <= (i < int'(pages_q)) ? PI'(int'(pages_q) - 1 - i) : '0;
        end
      end else begin
        // page count saturates at the table size
        pages_q <= (cfg_data[5:0] > 6'(NP)) ? 6'(NP) : cfg_data[5:0];
        total_q <= (cfg_data[5:0] > 6'(NP)) ? 6'(NP) : cfg_data[5:0];
        for (int i = 0; i < NP; i++) begin
          order_q[i] <= (i < int'(cfg_data[5:0]) && i < NP)
                        ? PI'(((int'(cfg_data[5:0]) > NP) ? NP : int'(cfg_data[5:0])) - 1 - i)
                        : '0;
        end
      end
      for (int i = 0; i < NP; i++) begin
        code_q[i] <= '0;
        fblk_q[i] <= '0;
      end
      for (int c = 0; c < NC; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        len_q[c]  <= '0;
      end
    end else begin
      case (state_q)
        scba_pkg::S_IDLE: begin
          if (s_tvalid) begin
            typ_q    <= s_tuser;
            size_q   <= s_tdata[15:0];
            addr_q   <= s_tdata[47:16];
            grant_q  <= s_tdata[48];
            r_status <= scba_pkg::ST_OK;
            r_addr   <= '0;
            r_paddr  <= '0;
            r_bytes  <= '0;
            r_claim  <= 1'b0;
            r_rel    <= 1'b0;
          end
        end
        scba_pkg::S_DECODE: begin
          case (typ_q)
            scba_pkg::REQ_ALLOC: begin
              if (size_q == '0) r_status <= scba_pkg::ST_ZERO;
              else if (too_big) r_status <= scba_pkg::ST_TOO_BIG;
              else if (a_hit) cls_q <= a_cls;
              else if (total_q != '0) begin
                r_claim <= 1'b1;
                r_paddr <= top_paddr;
                if (!grant_q) r_status <= scba_pkg::ST_REFUSED;
                else begin
                  r_addr <= top_paddr;
                  pg_q   <= top_pg;
                  cls_q  <= a_cls;
                  k_q    <= KW'(1);
                end
              end else if (d_found) cls_q <= d_cls;
              else r_status <= scba_pkg::ST_NO_BLOCK;
            end
            scba_pkg::REQ_FREE: begin
              if (!in_reg) r_status <= scba_pkg::ST_RANGE;
              else if (f_code == '0) r_status <= scba_pkg::ST_IGNORED;
              else begin
                if (len_q[f_cls] == '0) tail_q[f_cls] <= f_id;
                head_q[f_cls] <= f_id;
                if (len_q[f_cls] != '1) len_q[f_cls] <= len_q[f_cls] + 1'b1;
                fblk_q[f_pg] <= f_cnt;
                r_bytes <= f_sz;
                pg_q    <= f_pg;
                cls_q   <= f_cls;
              end
            end
            scba_pkg::REQ_QUERY: begin
              if (!in_reg) r_status <= scba_pkg::ST_RANGE;
              else if (f_code != '0) r_bytes <= f_sz;
            end
            default: r_status <= scba_pkg::ST_IGNORED;
          endcase
        end
        scba_pkg::S_POP: begin
          head_q[cls_q] <= link_q;
          len_q[cls_q]  <= len_q[cls_q] - 1'b1;
          fblk_q[head_q[cls_q][BI-1 -: PI]] <= fblk_q[head_q[cls_q][BI-1 -: PI]] - 1'b1;
          r_addr <= start_q + {{(32 - BI - scba_pkg::MIN_SHIFT){1'b0}}, head_q[cls_q],
                               {scba_pkg::MIN_SHIFT{1'b0}}};
        end
        scba_pkg::S_SPLIT: begin
          if (len_q[cls_q] == '0) head_q[cls_q] <= s_id;
          tail_q[cls_q] <= s_id;
          if (len_q[cls_q] != '1) len_q[cls_q] <= len_q[cls_q] + 1'b1;
          k_q <= k_q + 1'b1;
          if (k_q == s_last) begin
            code_q[pg_q] <= cls_q + 1'b1;
            fblk_q[pg_q] <= CW'(s_last);
            total_q      <= total_q - 1'b1;
          end
        end
        scba_pkg::S_WSTART: begin
          cur_q   <= head_q[cls_q];
          wlen_q  <= len_q[cls_q];
          widx_q  <= '0;
          wcnt_q  <= '0;
          whead_q <= '0;
          wtail_q <= '0;
        end
        scba_pkg::S_WALK: begin
          whead_q <= w_head;
          wtail_q <= w_tail;
          wcnt_q  <= w_cnt;
          cur_q   <= link_q;
          widx_q  <= widx_q + 1'b1;
          if (w_done) begin
            head_q[cls_q] <= w_head;
            tail_q[cls_q] <= w_tail;
            len_q[cls_q]  <= w_cnt;
            if (total_q < 6'(NP)) begin
              order_q[PI'(total_q)] <= pg_q;
              total_q <= total_q + 1'b1;
            end
            code_q[pg_q] <= '0;
            fblk_q[pg_q] <= '0;
            r_rel   <= 1'b1;
            r_paddr <= start_q + {pg_q, {scba_pkg::PAGE_SHIFT{1'b0}}};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q  <= scba_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state_q <= state_next;
      if (state_q == scba_pkg::S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_q == scba_pkg::S_OUT && (!m_tvalid || m_tready)) begin
      m_tuser <= r_status;
      m_tdata <= {2'b00, r_paddr, r_rel, r_claim, r_bytes, r_addr};
    end
  end

  `SCBA_ASSERT_NEXT(a_accept_decode, clk, rst, s_tvalid && s_tready,
                    state_q == scba_pkg::S_DECODE, "accepted item not decoded")
  `SCBA_ASSERT_SAME(a_split_index, clk, rst, state_q == scba_pkg::S_SPLIT, k_q != '0,
                    "split index zero")
  `SCBA_ASSERT_SAME(a_total_bound, clk, rst, 1'b1, total_q <= 6'(NP), "free page total overflow")
  `SCBA_ASSERT_SAME(a_reset_empty, clk, rst, $past(rst), total_q == '0, "pages free after reset")
  `SCBA_ASSERT_SAME(a_walk_len, clk, rst, state_q == scba_pkg::S_WALK, wlen_q != '0,
                    "walk over empty list")

endmodule

### sim/tb.sv
// testbench for size_class_block_allocator: random and directed alloc/free/query traffic
// checks every result against a local allocator model; depends on scba_pkg and the rtl
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] size;
    logic [31:0] addr;
    logic        grant;
  } alloc_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] block_addr;
    logic [11:0] bytes;
    logic        claimed;
    logic        released;
    logic [31:0] page_addr;
  } alloc_resp_t;

  // request type with no meaning, answered as ignored
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [31:0] cfg_data = '0;

  size_class_block_allocator dut (.*);

  always #2 clk = ~clk;

  // allocator model state
  logic [31:0] mdl_base;
  logic [5:0]  mdl_pages;
  logic [5:0]  mdl_free_pages;
  logic [4:0]  mdl_page_stack [scba_pkg::MAX_PAGES];
  logic [3:0]  mdl_page_class [scba_pkg::MAX_PAGES];
  logic [9:0]  mdl_page_avail [scba_pkg::MAX_PAGES];
  logic [13:0] mdl_link [scba_pkg::TOTAL_BLOCKS];
  logic [13:0] mdl_head [scba_pkg::NUM_CLASSES];
  logic [13:0] mdl_tail [scba_pkg::NUM_CLASSES];
  logic [14:0] mdl_len  [scba_pkg::NUM_CLASSES];

  alloc_req_t  request_queue[$];
  alloc_resp_t expected_results[$];
  logic [31:0] live_blocks[$];
  logic [31:0] freed_blocks[$];

  int  mismatches = 0;
  int  results_seen = 0;
  bit  in_taken = 0;
  bit  idling_on = 1;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  long_hold = 0;
  bit  long_hold_done = 0;

  function automatic int active_pages();
    return (mdl_pages > scba_pkg::MAX_PAGES) ? scba_pkg::MAX_PAGES : int'(mdl_pages);
  endfunction

  function automatic void rebuild_model();
    int n;
    n = active_pages();
    for (int i = 0; i < scba_pkg::MAX_PAGES; i++) begin
      mdl_page_stack[i] = (i < n) ? 5'(n - 1 - i) : '0;
      mdl_page_class[i] = '0;
      mdl_page_avail[i] = '0;
    end
    for (int i = 0; i < scba_pkg::TOTAL_BLOCKS; i++) mdl_link[i] = '0;
    for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
      mdl_head[c] = '0;
      mdl_tail[c] = '0;
      mdl_len[c] = '0;
    end
    mdl_free_pages = 6'(n);
  endfunction

  function automatic void write_register(logic idx, logic [31:0] val);
    if (idx == scba_pkg::CFG_REGION_START) mdl_base = val & 32'hFFFF_F000;
    else mdl_pages = val[5:0];
    rebuild_model();
  endfunction

  function automatic logic [31:0] page_base(int p);
    return mdl_base + 32'(p) * 32'd4096;
  endfunction

  function automatic logic [31:0] block_base(logic [13:0] id);
    return mdl_base + 32'(id >> scba_pkg::BPP_SHIFT) * 32'd4096 + 32'(id[8:0]) * 32'd8;
  endfunction

  function automatic logic [13:0] take_head(int c);
    logic [13:0] id;
    id = mdl_head[c];
    mdl_head[c] = mdl_link[id];
    mdl_len[c]--;
    mdl_page_avail[id >> scba_pkg::BPP_SHIFT]--;
    return id;
  endfunction

  function automatic void append_block(int c, logic [13:0] id);
    if (mdl_len[c] == 0) mdl_head[c] = id;
    else mdl_link[mdl_tail[c]] = id;
    mdl_tail[c] = id;
    if (mdl_len[c] != 15'h7FFF) mdl_len[c]++;
  endfunction

  function automatic void prepend_block(int c, logic [13:0] id);
    mdl_link[id] = mdl_head[c];
    if (mdl_len[c] == 0) mdl_tail[c] = id;
    mdl_head[c] = id;
    if (mdl_len[c] != 15'h7FFF) mdl_len[c]++;
  endfunction

  // unlink every block of page p from class c, keeping the others in order
  function automatic void strip_page(int c, int p);
    int n, cnt;
    logic [13:0] cur, nxt, hd, tl;
    n = mdl_len[c];
    cur = mdl_head[c];
    cnt = 0;
    hd = '0;
    tl = '0;
    for (int i = 0; i < n; i++) begin
      nxt = mdl_link[cur];
      if (int'(cur >> scba_pkg::BPP_SHIFT) != p) begin
        if (cnt == 0) hd = cur;
        else mdl_link[tl] = cur;
        tl = cur;
        cnt++;
      end
      cur = nxt;
    end
    mdl_head[c] = hd;
    mdl_tail[c] = tl;
    mdl_len[c] = 15'(cnt);
  endfunction

  function automatic alloc_resp_t predict_request(alloc_req_t rq);
    alloc_resp_t r;
    longint lo, hi, sz, off;
    int c, p, n, step;
    bit found;
    r = '{scba_pkg::ST_OK, '0, '0, 1'b0, 1'b0, '0};
    lo = longint'(mdl_base);
    hi = lo + longint'(active_pages()) * 4096;
    if (rq.kind == scba_pkg::REQ_ALLOC) begin
      if (rq.size == 0) r.status = scba_pkg::ST_ZERO;
      else if (rq.size > scba_pkg::MAX_CLASS_BYTES) r.status = scba_pkg::ST_TOO_BIG;
      else begin
        sz = 8;
        c = 0;
        while (sz < rq.size) begin
          sz = sz * 2;
          c++;
        end
        if (mdl_len[c] != 0) r.block_addr = block_base(take_head(c));
        else if (mdl_free_pages != 0) begin
          p = mdl_page_stack[mdl_free_pages - 1];
          r.claimed = 1;
          r.page_addr = page_base(p);
          if (!rq.grant) r.status = scba_pkg::ST_REFUSED;
          else begin
            n = int'(4096 / sz);
            step = int'(sz / 8);
            mdl_free_pages--;
            for (int k = 1; k < n; k++) append_block(c, 14'(p * 512 + k * step));
            mdl_page_class[p] = 4'(c + 1);
            mdl_page_avail[p] = 10'(n - 1);
            r.block_addr = r.page_addr;
          end
        end else begin
          r.status = scba_pkg::ST_NO_BLOCK;
          found = 0;
          for (int d = c + 1; d < scba_pkg::NUM_CLASSES; d++)
            if (!found && mdl_len[d] != 0) begin
              r.block_addr = block_base(take_head(d));
              r.status = scba_pkg::ST_OK;
              found = 1;
            end
        end
      end
      if (r.status == scba_pkg::ST_OK) live_blocks.push_back(r.block_addr);
    end else if (rq.kind == scba_pkg::REQ_FREE || rq.kind == scba_pkg::REQ_QUERY) begin
      if (longint'(rq.addr) < lo || longint'(rq.addr) >= hi) r.status = scba_pkg::ST_RANGE;
      else begin
        p = int'((longint'(rq.addr) - lo) / 4096);
        if (rq.kind == scba_pkg::REQ_QUERY) begin
          if (mdl_page_class[p] != 0) r.bytes = 12'(8 << (mdl_page_class[p] - 1));
        end else if (mdl_page_class[p] == 0) r.status = scba_pkg::ST_IGNORED;
        else begin
          c = mdl_page_class[p] - 1;
          sz = 8 << c;
          off = (longint'(rq.addr) - lo) % 4096;
          off = off - off % sz;
          prepend_block(c, 14'(p * 512 + off / 8));
          r.bytes = 12'(sz);
          mdl_page_avail[p]++;
          if (int'(mdl_page_avail[p]) == 4096 / sz) begin
            strip_page(c, p);
            if (mdl_free_pages < scba_pkg::MAX_PAGES) begin
              mdl_page_stack[mdl_free_pages] = 5'(p);
              mdl_free_pages++;
            end
            mdl_page_class[p] = '0;
            mdl_page_avail[p] = '0;
            r.released = 1;
            r.page_addr = page_base(p);
          end
        end
      end
    end else r.status = scba_pkg::ST_IGNORED;
    return r;
  endfunction

  function automatic void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %h got %h", $realtime, what, exp_v, got_v);
  endfunction

  // scoreboard and model update, both at the rising edge
  always @(posedge clk) begin
    alloc_resp_t ex;
    alloc_req_t  rq;
    if (!rst) begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) report("unexpected item", '0, m_tdata[31:0]);
        else begin
          ex = expected_results.pop_front();
          if (m_tuser != ex.status) report("status", 32'(ex.status), 32'(m_tuser));
          if (m_tdata[31:0] != ex.block_addr) report("result_address", ex.block_addr,
                                                     m_tdata[31:0]);
          if (m_tdata[43:32] != ex.bytes) report("block_bytes", 32'(ex.bytes),
                                                 32'(m_tdata[43:32]));
          if (m_tdata[44] != ex.claimed) report("page_claimed", 32'(ex.claimed),
                                                32'(m_tdata[44]));
          if (m_tdata[45] != ex.released) report("page_released", 32'(ex.released),
                                                 32'(m_tdata[45]));
          if (m_tdata[77:46] != ex.page_addr) report("page_address", ex.page_addr,
                                                     m_tdata[77:46]);
        end
      end
      if (s_tvalid && s_tready) begin
        rq.kind = s_tuser;
        rq.size = s_tdata[15:0];
        rq.addr = s_tdata[47:16];
        rq.grant = s_tdata[48];
        expected_results.push_back(predict_request(rq));
      end
    end
    in_taken <= s_tvalid && s_tready;
  end

  // request driver
  always @(negedge clk) begin
    alloc_req_t rq;
    if (!rst && (!s_tvalid || in_taken)) begin
      if (send_gap > 0) begin
        s_tvalid <= 0;
        send_gap--;
      end else if (request_queue.size() > 0) begin
        rq = request_queue.pop_front();
        s_tuser <= rq.kind;
        s_tdata <= {7'd0, rq.grant, rq.addr, rq.size};
        s_tvalid <= 1;
        if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
      end else s_tvalid <= 0;
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else if (!long_hold_done && results_seen >= 40) begin
      long_hold_done = 1;
      long_hold = 300;
      m_tready <= 0;
    end else if (long_hold > 0) begin
      long_hold--;
      m_tready <= 0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
      if (idling_on && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 9);
    end
  end

  task automatic send(logic [1:0] kind, logic [15:0] size, logic [31:0] addr, logic grant);
    request_queue.push_back('{kind, size, addr, grant});
  endtask

  task automatic wait_quiet();
    do begin
      @(posedge clk);
      #1;
    end while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  task automatic set_region(logic [31:0] start, logic [31:0] pages);
    wait_quiet();
    repeat (20) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= scba_pkg::CFG_REGION_START;
    cfg_data <= start;
    @(negedge clk);
    cfg_index <= scba_pkg::CFG_REGION_PAGES;
    cfg_data <= pages;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [15:0] pick_size();
    int c;
    c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(3, 8);
    return 16'($urandom_range(c == 0 ? 1 : (8 << (c - 1)) + 1, 8 << c));
  endfunction

  // one random item: mostly well-formed alloc/free traffic, some noise
  task automatic random_item();
    int r, i;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    if (r < 42) send(scba_pkg::REQ_ALLOC, pick_size(), $urandom, $urandom_range(0, 19) != 0);
    else if (r < 80 && live_blocks.size() > 0) begin
      i = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[i];
      live_blocks.delete(i);
      freed_blocks.push_back(a);
      if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
      if ($urandom_range(0, 3) == 0) a = a + $urandom_range(1, 7);
      send(scba_pkg::REQ_FREE, 16'($urandom), a, 1'($urandom));
    end else if (r < 88) begin
      a = (live_blocks.size() > 0) ? live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                                   : mdl_base + $urandom_range(0, 131071);
      send(scba_pkg::REQ_QUERY, 16'($urandom), a, 1'($urandom));
    end else if (r < 91) send(REQ_UNKNOWN, 16'($urandom), $urandom, 1'($urandom));
    else if (r < 94) send(scba_pkg::REQ_FREE, 16'($urandom), $urandom, 1'($urandom));
    else if (r < 96 && freed_blocks.size() > 0)
      send(scba_pkg::REQ_FREE, 16'($urandom),
           freed_blocks[$urandom_range(0, freed_blocks.size() - 1)], 1);
    else if (r < 98) send(scba_pkg::REQ_ALLOC, 16'($urandom), $urandom, 1);
    else send(scba_pkg::REQ_ALLOC, 16'd0, $urandom, 1);
  endtask

  task automatic random_phase(logic [31:0] start, logic [31:0] pages, int count, bit last);
    set_region(start, pages);
    live_blocks.delete();
    freed_blocks.delete();
    for (int k = 0; k < count; k += 6) begin
      wait (request_queue.size() == 0);
      if (last && k >= count - 60) idling_on = 0;
      repeat (6) random_item();
    end
  endtask

  initial begin
    logic [31:0] b;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: one page, fallback to larger class, full release, error codes
    b = 32'h1000_0000;
    set_region(b, 1);
    send(scba_pkg::REQ_ALLOC, 16'd0, '0, 1);
    send(scba_pkg::REQ_ALLOC, 16'hFFFF, '0, 1);
    send(scba_pkg::REQ_ALLOC, 16'd2049, '0, 1);
    send(scba_pkg::REQ_ALLOC, 16'd1000, '0, 0);
    send(scba_pkg::REQ_ALLOC, 16'd1024, '0, 1);
    send(scba_pkg::REQ_QUERY, '0, b + 32'd5, 0);
    send(scba_pkg::REQ_ALLOC, 16'd1, '0, 1);
    send(scba_pkg::REQ_ALLOC, 16'd8, '0, 1);
    send(scba_pkg::REQ_ALLOC, 16'd16, '0, 1);
    send(scba_pkg::REQ_ALLOC, 16'd8, '0, 1);
    send(scba_pkg::REQ_FREE, '0, b + 32'd3072 + 32'd5, 0);
    send(scba_pkg::REQ_FREE, '0, b + 32'd2048, 0);
    send(scba_pkg::REQ_FREE, '0, b + 32'd1024, 0);
    send(scba_pkg::REQ_FREE, '0, b, 0);
    send(scba_pkg::REQ_QUERY, '0, b + 32'd1, 0);
    send(scba_pkg::REQ_FREE, '0, b + 32'd8, 0);
    send(scba_pkg::REQ_FREE, '0, b + 32'd4096, 0);
    send(scba_pkg::REQ_QUERY, '0, b - 32'd1, 0);
    send(REQ_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF, 1);
    send(scba_pkg::REQ_ALLOC, 16'd2048, '0, 1);
    send(scba_pkg::REQ_FREE, '0, b + 32'd100, 1);
    // directed: no pages at all
    set_region(32'hFFFF_FFFF, 0);
    send(scba_pkg::REQ_ALLOC, 16'd8, '0, 1);
    send(scba_pkg::REQ_QUERY, '0, 32'hFFFF_F000, 1);
    send(scba_pkg::REQ_FREE, '0, '0, 1);

    random_phase(32'h0000_0000, 32, 150, 0);
    random_phase(32'hFFFF_F000, 32, 110, 0);
    random_phase(32'h1234_5678, 3, 110, 0);
    random_phase(32'h8000_0FFF, 63, 120, 0);
    random_phase(32'h4000_0000, 2, 70, 1);

    wait_quiet();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #400ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_ram.sv
rtl/size_class_block_allocator.sv
sim/tb.sv
